// ----- src/rbs_pkg.sv -----
`timescale 1ns / 1ps

package rbs_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DOUBLE,
      ST_DIV_Q,
      ST_DIV_SETUP,
      ST_DIV_R,
      ST_FIN_DELAY,
      ST_FIN_DEADLINE,
      ST_HASH,
      ST_SEED,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_COLD,
      PH_ATTEMPTING,
      PH_WAITING,
      PH_CONNECTED
   } phase_type;

   // request kinds (req_tuser)
   localparam logic [2:0] MODE_TICK           = 3'd0;
   localparam logic [2:0] MODE_CONNECTED      = 3'd1;
   localparam logic [2:0] MODE_DISCONNECTED   = 3'd2;
   localparam logic [2:0] MODE_ATTEMPT_FAILED = 3'd3;
   localparam logic [2:0] MODE_RESET          = 3'd4;
   localparam logic [2:0] MODE_RESEED         = 3'd5;

   // register map
   localparam logic [2:0] CSR_INITIAL_BACKOFF = 3'd0;
   localparam logic [2:0] CSR_MAX_BACKOFF     = 3'd1;
   localparam logic [2:0] CSR_JITTER_DIVISOR  = 3'd2;
   localparam logic [2:0] CSR_ATTEMPT_TIMEOUT = 3'd3;
   localparam logic [2:0] CSR_DEVICE_MAC      = 3'd4;

   localparam logic [31:0] INITIAL_BACKOFF_RST = 32'd1000;
   localparam logic [31:0] MAX_BACKOFF_RST     = 32'd300000;
   localparam logic [7:0]  JITTER_DIVISOR_RST  = 8'd4;
   localparam logic [31:0] ATTEMPT_TIMEOUT_RST = 32'd10000;
   localparam logic [47:0] DEVICE_MAC_RST      = 48'd0;

   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] SEED_MASK = 32'h5E7B1CE5;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam int          MAC_BYTES = 6;

   localparam int XS_SHIFT_A = 13;
   localparam int XS_SHIFT_B = 17;
   localparam int XS_SHIFT_C = 5;

   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] x;
      x = s ^ (s << XS_SHIFT_A);
      x = x ^ (x >> XS_SHIFT_B);
      x = x ^ (x << XS_SHIFT_C);
      return x;
   endfunction

endpackage

// ----- src/reconnect_backoff_scheduler.sv -----
`timescale 1ns / 1ps

// Reconnect backoff scheduler.
// req: one word per event; req_tuser is the kind (tick, connected, disconnected,
//    attempt failed, reset, reseed), req_tdata the current ms time for a tick.
// rsp: one word per request with the attempt pulse, phase, retry delay and
//    failure count as they stand after the request.
// csr: write-only register port, taken on any cycle with csr_we high; change
//    registers only while no request is in flight.
// One request is worked at a time; req_tready is low from accept until the
// result is loaded into the output register.
// Work from accept to rsp_tvalid: plain events go straight from ST_EXEC to ST_DONE;
// a reseed hashes the MAC bytes (one hash byte per cycle), then seeds the
// generator; a failure doubles the base, then makes two passes of the shared
// restoring divider (base / divisor, then the draw modulo quotient + 1). The next
// request is taken once the word is loaded and the sequencer is back in idle.
// A stalled rsp holds its word; a finished request waits in the last sequencer
// state until the output register is free, and the next request waits behind it.
// Reset (synchronous) puts the scheduler cold with zero counts, the generator
// at 1 and the registers at their defaults; the block is ready right away.
module reconnect_backoff_scheduler import rbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] now_ms
   input  logic [2:0]  req_tuser,   // [2:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [0] attempt_due, [2:1] phase_now,
                                    // [34:3] retry_delay_ms, [50:35] attempt_count
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [47:0] csr_wdata
);

   localparam logic [4:0] DIV_LAST  = 5'd31;
   localparam logic [4:0] HASH_LAST = 5'(MAC_BYTES - 1);

   seq_state_type state_ff, state_in;

   logic [31:0] init_ff, max_ff, timeout_ff;
   logic [7:0]  jdiv_ff;
   logic [47:0] mac_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] failures_ff, failures_in;
   logic [31:0] delay_ff, delay_in;
   logic [31:0] retry_dl_ff, retry_dl_in;
   logic [31:0] attempt_dl_ff, attempt_dl_in;
   logic [31:0] last_ff, last_in;
   logic        due_ff, due_in;
   logic [31:0] prng_ff, prng_in;

   logic [2:0]  mode_ff;
   logic [31:0] now_ff;
   logic [31:0] base_ff, base_in;
   logic [15:0] steps_ff, steps_in;
   logic [31:0] work_ff, work_in;
   logic [31:0] rem_ff, rem_in;
   logic [32:0] dsor_ff, dsor_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        exec_fail, exec_reseed;
   logic [31:0] retry_diff, attempt_diff;
   logic [15:0] fail_cnt;
   logic        dbl_cont, dbl_step;
   logic [31:0] base_sat;
   logic [7:0]  jdiv_eff;
   logic [32:0] trial, diff;
   logic        ge;
   logic [31:0] rem_step, work_step;
   logic        div_last;
   logic [7:0]  mac_byte;
   logic [31:0] hash_x, hash_step, seed_val, draw;
   logic        out_free;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // deadline reached when (now - deadline) mod 2^32 < 2^31
   assign retry_diff   = now_ff - retry_dl_ff;
   assign attempt_diff = now_ff - attempt_dl_ff;
   assign fail_cnt     = (failures_ff == COUNT_MAX) ? failures_ff : failures_ff + 16'd1;

   assign dbl_cont = (steps_ff != 16'd0) && (base_ff != 32'd0) && (base_ff < max_ff);
   assign dbl_step = dbl_cont && !base_ff[31];
   // leaving the loop with the top bit set means the next doubling would overflow
   assign base_sat = (dbl_cont || base_ff >= max_ff) ? max_ff : base_ff;
   assign jdiv_eff = (jdiv_ff == 8'd0) ? 8'd1 : jdiv_ff;

   // shared restoring divider step: quotient shifts into work_ff
   assign trial     = {rem_ff, work_ff[31]};
   assign ge        = (trial >= dsor_ff);
   assign diff      = trial - dsor_ff;
   assign rem_step  = ge ? diff[31:0] : trial[31:0];
   assign work_step = {work_ff[30:0], ge};
   assign div_last  = (cnt_ff == DIV_LAST);

   always_comb begin
      case (cnt_ff[2:0])
         3'd0:    mac_byte = mac_ff[47:40];
         3'd1:    mac_byte = mac_ff[39:32];
         3'd2:    mac_byte = mac_ff[31:24];
         3'd3:    mac_byte = mac_ff[23:16];
         3'd4:    mac_byte = mac_ff[15:8];
         default: mac_byte = mac_ff[7:0];
      endcase
   end

   assign hash_x    = work_ff ^ {24'd0, mac_byte};
   assign hash_step = 32'(hash_x * FNV_PRIME);
   assign seed_val  = work_ff ^ SEED_MASK;
   assign draw      = xorshift32(prng_ff);

   // request decode
   always_comb begin
      exec_fail   = 1'b0;
      exec_reseed = 1'b0;
      unique case (mode_ff)
         MODE_TICK:           exec_fail = (phase_ff == PH_ATTEMPTING) && !attempt_diff[31];
         MODE_DISCONNECTED:   exec_fail = (phase_ff == PH_ATTEMPTING) ||
                                          (phase_ff == PH_CONNECTED);
         MODE_ATTEMPT_FAILED: exec_fail = (phase_ff == PH_ATTEMPTING);
         MODE_RESEED:         exec_reseed = 1'b1;
         default:             exec_fail = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:         if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_fail)        state_in = ST_DOUBLE;
            else if (exec_reseed) state_in = ST_HASH;
            else                  state_in = ST_DONE;
         end
         ST_DOUBLE:       if (!dbl_step) state_in = ST_DIV_Q;
         ST_DIV_Q:        if (div_last) state_in = ST_DIV_SETUP;
         ST_DIV_SETUP:    state_in = ST_DIV_R;
         ST_DIV_R:        if (div_last) state_in = ST_FIN_DELAY;
         ST_FIN_DELAY:    state_in = ST_FIN_DEADLINE;
         ST_FIN_DEADLINE: state_in = ST_DONE;
         ST_HASH:         if (cnt_ff == HASH_LAST) state_in = ST_SEED;
         ST_SEED:         state_in = ST_DONE;
         ST_DONE:         if (out_free) state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      phase_in      = phase_ff;
      failures_in   = failures_ff;
      delay_in      = delay_ff;
      retry_dl_in   = retry_dl_ff;
      attempt_dl_in = attempt_dl_ff;
      last_in       = last_ff;
      due_in        = due_ff;
      prng_in       = prng_ff;
      base_in       = base_ff;
      steps_in      = steps_ff;
      work_in       = work_ff;
      rem_in        = rem_ff;
      dsor_in       = dsor_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_EXEC: begin
            case (mode_ff)
               MODE_TICK: begin
                  last_in = now_ff;
                  due_in  = 1'b0;
                  if (phase_ff == PH_COLD ||
                      (phase_ff == PH_WAITING && !retry_diff[31])) begin
                     phase_in      = PH_ATTEMPTING;
                     attempt_dl_in = now_ff + timeout_ff;
                     due_in        = 1'b1;
                  end
               end
               MODE_CONNECTED: begin
                  phase_in    = PH_CONNECTED;
                  failures_in = 16'd0;
                  delay_in    = 32'd0;
                  due_in      = 1'b0;
               end
               MODE_RESET: begin
                  phase_in    = PH_COLD;
                  failures_in = 16'd0;
                  delay_in    = 32'd0;
                  due_in      = 1'b0;
               end
               default: begin
               end
            endcase
            if (exec_fail) begin
               failures_in = fail_cnt;
               base_in     = init_ff;
               steps_in    = fail_cnt - 16'd1;
            end
            if (exec_reseed) begin
               work_in = FNV_BASIS;
               cnt_in  = 5'd0;
            end
         end
         ST_DOUBLE: begin
            if (dbl_step) begin
               base_in  = {base_ff[30:0], 1'b0};
               steps_in = steps_ff - 16'd1;
            end else begin
               base_in = base_sat;
               work_in = base_sat;
               rem_in  = 32'd0;
               dsor_in = {25'd0, jdiv_eff};
               cnt_in  = 5'd0;
            end
         end
         ST_DIV_Q, ST_DIV_R: begin
            rem_in  = rem_step;
            work_in = work_step;
            cnt_in  = cnt_ff + 5'd1;
         end
         ST_DIV_SETUP: begin
            // quotient + 1 can reach 2^32
            dsor_in = {1'b0, work_ff} + 33'd1;
            work_in = draw;
            prng_in = draw;
            rem_in  = 32'd0;
            cnt_in  = 5'd0;
         end
         ST_FIN_DELAY: delay_in = base_ff - rem_ff;
         ST_FIN_DEADLINE: begin
            retry_dl_in = last_ff + delay_ff;
            phase_in    = PH_WAITING;
            due_in      = 1'b0;
         end
         ST_HASH: begin
            work_in = hash_step;
            cnt_in  = cnt_ff + 5'd1;
         end
         ST_SEED: prng_in = (seed_val == 32'd0) ? 32'd1 : seed_val;
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, failures_ff,
                               (phase_ff == PH_WAITING) ? delay_ff : 32'd0,
                               phase_ff, due_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_COLD;
         failures_ff   <= 16'd0;
         delay_ff      <= 32'd0;
         retry_dl_ff   <= 32'd0;
         attempt_dl_ff <= 32'd0;
         last_ff       <= 32'd0;
         due_ff        <= 1'b0;
         prng_ff       <= 32'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         failures_ff   <= failures_in;
         delay_ff      <= delay_in;
         retry_dl_ff   <= retry_dl_in;
         attempt_dl_ff <= attempt_dl_in;
         last_ff       <= last_in;
         due_ff        <= due_in;
         prng_ff       <= prng_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_tuser;
         now_ff  <= req_tdata;
      end
      base_ff     <= base_in;
      steps_ff    <= steps_in;
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      dsor_ff     <= dsor_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= INITIAL_BACKOFF_RST;
         max_ff     <= MAX_BACKOFF_RST;
         jdiv_ff    <= JITTER_DIVISOR_RST;
         timeout_ff <= ATTEMPT_TIMEOUT_RST;
         mac_ff     <= DEVICE_MAC_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_INITIAL_BACKOFF: init_ff    <= csr_wdata[31:0];
            CSR_MAX_BACKOFF:     max_ff     <= csr_wdata[31:0];
            CSR_JITTER_DIVISOR:  jdiv_ff    <= csr_wdata[7:0];
            CSR_ATTEMPT_TIMEOUT: timeout_ff <= csr_wdata[31:0];
            CSR_DEVICE_MAC:      mac_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // the pulse only ever stands while an attempt is open
   a_due_attempting: assert property (@(posedge clock) disable iff (reset)
      due_ff |-> phase_ff == PH_ATTEMPTING)
      else $error("attempt pulse outside attempting phase");

   // waiting is only reached through a counted failure
   a_wait_counted: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAITING |-> failures_ff != 16'd0)
      else $error("waiting with zero failures");

   // divider partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_Q || state_ff == ST_DIV_R) |-> {1'b0, rem_ff} < dsor_ff)
      else $error("divider remainder out of range");

   // delay field is zero unless the reported phase is waiting
   a_rsp_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[2:1] != PH_WAITING |-> rsp_data_ff[34:3] == 32'd0)
      else $error("retry delay reported outside waiting");

   // one request at a time
   a_single: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second request taken while busy");
`endif

endmodule
